/* design/mqlf_pkg.sv */
// Shared types and codes for the linked multi-queue FIFO.
`default_nettype none
package mqlf_pkg;

  localparam int KEY_W  = 8;
  localparam int QIDX_W = 4;
  localparam int STAT_W = 2;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Classified command passed from the front end to the engine.
  typedef struct packed {
    logic              op;
    logic [QIDX_W-1:0] queue_index;
    logic [KEY_W-1:0]  data_key;
    logic              q_ok;
  } cmd_t;

endpackage
`default_nettype wire

/* design/mqlf_if.sv */
// Command and result channel interfaces.
`default_nettype none
interface mqlf_cmd_if;
  import mqlf_pkg::*;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [QIDX_W-1:0] queue_index;
  logic [KEY_W-1:0]  data_key;

  modport source (output valid, operation, queue_index, data_key, input ready);
  modport sink   (input valid, operation, queue_index, data_key, output ready);
endinterface

interface mqlf_res_if;
  import mqlf_pkg::*;
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  removed_key;
  logic [STAT_W-1:0] status;

  modport source (output valid, removed_key, status, input ready);
  modport sink   (input valid, removed_key, status, output ready);
endinterface
`default_nettype wire

/* design/mqlf_front.sv */
// Front end: accepts command beats, checks the queue index, buffers two deep.
`default_nettype none
module mqlf_front #(
  parameter int NUM_QUEUES = 10
) (
  input  wire logic           clk,
  input  wire logic           rst,
  mqlf_cmd_if.sink            cmd,
  output mqlf_pkg::cmd_t      link_cmd,
  output logic                link_valid,
  input  wire logic           link_ready
);
  import mqlf_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  cmd_t       in_cmd;

  always_comb begin
    in_cmd.op          = cmd.operation;
    in_cmd.queue_index = cmd.queue_index;
    in_cmd.data_key    = cmd.data_key;
    in_cmd.q_ok        = 32'(cmd.queue_index) < 32'(NUM_QUEUES);
  end

  assign cmd.ready  = (count != 2'd2);
  assign link_valid = (count != 2'd0);
  assign link_cmd   = slot[rd_ptr];
  assign push       = cmd.valid && cmd.ready;
  assign pop        = link_valid && link_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

/* design/mqlf_engine.sv */
// Back end: pointer tables, shared entry pool, free chain and result register.
`default_nettype none
module mqlf_engine #(
  parameter int NUM_QUEUES   = 10,
  parameter int POOL_ENTRIES = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mqlf_pkg::cmd_t link_cmd,
  input  wire logic           link_valid,
  output logic                link_ready,
  mqlf_res_if.source          res
);
  import mqlf_pkg::*;

  localparam int PW  = $clog2(POOL_ENTRIES);
  localparam int CW  = $clog2(POOL_ENTRIES + 1);
  localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int QIW = (QW > QIDX_W) ? QW : QIDX_W;
  localparam logic [PW-1:0] LAST_ENTRY = PW'(POOL_ENTRIES - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_LINK  = 2'd2;

  logic [KEY_W-1:0] key_mem  [POOL_ENTRIES];
  logic [PW-1:0]    next_mem [POOL_ENTRIES];
  logic [PW-1:0]    head_mem [NUM_QUEUES];
  logic [PW-1:0]    tail_mem [NUM_QUEUES];

  logic [KEY_W-1:0] key_rd;
  logic [PW-1:0]    next_rd;
  logic [PW-1:0]    head_rd;
  logic [PW-1:0]    tail_rd;

  logic [1:0]            state;
  cmd_t                  cur;
  logic [PW-1:0]         free_head;
  logic [CW-1:0]         free_count;
  logic [CW-1:0]         fill;      // entries at or above this were never allocated
  logic [NUM_QUEUES-1:0] nonempty;
  logic                  res_valid;
  logic [KEY_W-1:0]      res_key;
  logic [STAT_W-1:0]     res_status;

  logic [QIW-1:0] in_q_ext;
  logic [QIW-1:0] cur_q_ext;
  logic [QW-1:0]  in_q;
  logic [QW-1:0]  cur_q;
  logic [QW-1:0]  q_addr;
  logic [PW-1:0]  next_raddr;
  logic           take;
  logic           in_err;
  logic           untouched;
  logic [PW-1:0]  alloc_next;
  logic           do_append;
  logic           do_remove;
  logic           next_we;
  logic [PW-1:0]  next_waddr;
  logic [PW-1:0]  next_wdata;
  logic           res_load;

  assign in_q_ext  = QIW'(link_cmd.queue_index);
  assign cur_q_ext = QIW'(cur.queue_index);
  assign in_q      = in_q_ext[QW-1:0];
  assign cur_q     = cur_q_ext[QW-1:0];

  assign take       = (state == S_IDLE) && link_valid && (!res_valid || res.ready);
  assign link_ready = take;

  always_comb begin
    if (!link_cmd.q_ok) begin
      in_err = 1'b1;
    end else if (link_cmd.op == OP_APPEND) begin
      in_err = (free_count == '0);
    end else begin
      in_err = !nonempty[in_q];
    end
  end

  // Entries at or above the high-water mark take the implied link i -> i+1 (the last links to 0).
  assign untouched  = (CW'(free_head) >= fill);
  always_comb begin
    if (!untouched) begin
      alloc_next = next_rd;
    end else if (free_head == LAST_ENTRY) begin
      alloc_next = '0;
    end else begin
      alloc_next = free_head + PW'(1);
    end
  end

  assign do_append  = (state == S_FETCH) && (cur.op == OP_APPEND);
  assign do_remove  = (state == S_LINK);
  assign q_addr     = (state == S_IDLE) ? in_q : cur_q;
  assign next_raddr = (state == S_IDLE) ? free_head : head_rd;

  assign next_we    = (do_append && nonempty[cur_q]) || do_remove;
  assign next_waddr = do_remove ? head_rd : tail_rd;
  assign next_wdata = do_remove ? free_head : free_head;

  assign res_load   = (take && in_err) || do_append || do_remove;

  // Pool and pointer tables; reads are registered every cycle.
  always_ff @(posedge clk) begin
    head_rd <= head_mem[q_addr];
    tail_rd <= tail_mem[q_addr];
    next_rd <= next_mem[next_raddr];
    key_rd  <= key_mem[head_rd];
    if (do_append) begin
      key_mem[free_head] <= cur.data_key;
      tail_mem[cur_q]    <= free_head;
      if (!nonempty[cur_q]) begin
        head_mem[cur_q] <= free_head;
      end
    end
    if (do_remove && (head_rd != tail_rd)) begin
      head_mem[cur_q] <= next_rd;
    end
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= link_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_head  <= '0;
      free_count <= CW'(POOL_ENTRIES);
      fill       <= '0;
      nonempty   <= '0;
      res_valid  <= 1'b0;
      res_key    <= '0;
      res_status <= ST_OK;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && res.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            if (in_err) begin
              res_key    <= '0;
              res_status <= (link_cmd.op == OP_APPEND) ? ST_FULL : ST_EMPTY;
            end else begin
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          if (cur.op == OP_APPEND) begin
            free_head       <= alloc_next;
            free_count      <= free_count - CW'(1);
            nonempty[cur_q] <= 1'b1;
            if (untouched) begin
              fill <= fill + CW'(1);
            end
            res_key    <= '0;
            res_status <= ST_OK;
            state      <= S_IDLE;
          end else begin
            state <= S_LINK;
          end
        end
        S_LINK: begin
          if (head_rd == tail_rd) begin
            nonempty[cur_q] <= 1'b0;
          end
          free_head  <= head_rd;
          free_count <= free_count + CW'(1);
          res_key    <= key_rd;
          res_status <= ST_OK;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid       = res_valid;
  assign res.removed_key = res_key;
  assign res.status      = res_status;

endmodule
`default_nettype wire

/* design/multi_queue_linked_fifo.sv */
// Several FIFO queues of byte keys sharing one pool of linked entries. Each
// command beat appends a key to a queue or removes its oldest key, and gives
// exactly one result beat with the removed key and a status (ok, removal from
// an empty queue, or pool full on append; an index past the last queue counts
// as an empty queue with no room). A rejected command changes nothing. A
// two-deep command buffer decouples the input from the engine, and a result
// register holds the answer while the next command is taken in. The engine
// handles one command at a time: an error is answered from the idle state,
// an append passes through a fetch state and a removal through fetch and link
// states, since the reads of the queue pointer tables are registered and are
// followed by the read of the head entry in the pool. No clearing pass is
// needed after reset: a high-water mark stands in for the initial free chain.
`default_nettype none
module multi_queue_linked_fifo #(
  parameter int NUM_QUEUES   = 10,
  parameter int POOL_ENTRIES = 64
) (
  input  wire logic  clk,
  input  wire logic  rst,
  mqlf_cmd_if.sink   cmd,
  mqlf_res_if.source res
);
  import mqlf_pkg::*;

  cmd_t link_cmd;
  logic link_valid;
  logic link_ready;

  mqlf_front #(
    .NUM_QUEUES (NUM_QUEUES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .link_cmd   (link_cmd),
    .link_valid (link_valid),
    .link_ready (link_ready)
  );

  mqlf_engine #(
    .NUM_QUEUES   (NUM_QUEUES),
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .link_cmd   (link_cmd),
    .link_valid (link_valid),
    .link_ready (link_ready),
    .res        (res)
  );

  // A result still waiting on the sink holds the engine off.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |-> !link_ready)
    else $error("engine took a command while its result was waiting");

  // A bad queue index is answered in the next cycle with the matching error.
  a_bad_index: assert property (@(posedge clk) disable iff (rst)
    link_valid && link_ready && !link_cmd.q_ok |=> res.valid &&
      (($past(link_cmd.op) == OP_APPEND && res.status == ST_FULL) ||
       ($past(link_cmd.op) == OP_REMOVE && res.status == ST_EMPTY)))
    else $error("bad queue index not rejected");

  // Failed commands carry a zero key.
  a_err_key_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status != ST_OK |-> res.removed_key == '0)
    else $error("nonzero key on error result");

endmodule
`default_nettype wire
